### src/bfdh_pkg.sv
// ----------------------------------------------------------------------------
// bfdh_pkg
// Types and constants for the double-hashing bloom filter unit: sequencer
// states, register indexes and reset values, command codes, field widths.
// ----------------------------------------------------------------------------
package bfdh_pkg;

    // fixed field widths
    localparam int HASH_W      = 64;
    localparam int CFG_BITS_W  = 17;
    localparam int CFG_PROBE_W = 5;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_IDX_W   = 1;

    // divider step counter, one dividend bit per step of the remainder-only divider
    localparam int DIV_CNT_W = $clog2(HASH_W);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BITS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT = 1'd1;

    // register reset values
    localparam logic [CFG_BITS_W-1:0]  BITS_IN_USE_RST = 17'd65536;
    localparam logic [CFG_PROBE_W-1:0] PROBE_COUNT_RST = 5'd7;

    // command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_ACCESS,
        ST_LOOKUP,
        ST_DONE
    } t_state;

endpackage

### src/bloom_filter_double_hash_unit.sv
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_unit
// One request at a time: a new one is taken only in the idle state, after the
// last is done. An add sets k bits, k the probe count in use; a query tests
// up to k and stops at the first clear bit. Each probe index is reduced by
// the 64-step shared restoring divider.
// Reset: after reset the bit store is swept clear, one bit per cycle, for
// all MAX_BITS bits before the first request is taken; config writes are taken.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_unit
    import bfdh_pkg::*;
#(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_PROBES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,

    // request channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_cmd,
    input  logic [HASH_W-1:0]      i_first_hash,
    input  logic [HASH_W-1:0]      i_second_hash,

    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_maybe_present
);

    localparam int AW  = $clog2(MAX_BITS);
    localparam int MW  = $clog2(MAX_BITS + 1);
    localparam int PW  = $clog2(MAX_PROBES + 1);
    localparam int BCW = (MW > CFG_BITS_W) ? MW : CFG_BITS_W;
    localparam int PCW = (PW > CFG_PROBE_W) ? PW : CFG_PROBE_W;

    // control registers
    t_state                  r_state, n_state;
    logic [AW-1:0]           r_clr_addr, n_clr_addr;
    logic                    r_out_valid, n_out_valid;
    logic [CFG_BITS_W-1:0]   r_bits_in_use;
    logic [CFG_PROBE_W-1:0]  r_probe_count;

    // payload registers
    logic                    r_out_mp, n_out_mp;
    logic                    r_cmd, n_cmd;
    logic [HASH_W-1:0]       r_acc, n_acc;
    logic [HASH_W-1:0]       r_dvd, n_dvd;
    logic [HASH_W-1:0]       r_stride, n_stride;
    logic [MW-1:0]           r_m, n_m;
    logic [PW-1:0]           r_k, n_k;
    logic [PW-1:0]           r_probe, n_probe;
    logic [DIV_CNT_W-1:0]    r_cnt, n_cnt;
    logic [MW-1:0]           r_rem, n_rem;
    logic                    r_answer, n_answer;

    // bit store
    logic                    r_mem [MAX_BITS];
    logic                    r_rd_data;
    logic                    w_mem_we;
    logic                    w_mem_wd;
    logic [AW-1:0]           w_mem_addr;

    // datapath helpers
    logic [BCW-1:0]          w_bits_ext;
    logic [PCW-1:0]          w_probes_ext;
    logic [MW-1:0]           w_m_eff;
    logic [PW-1:0]           w_k_eff;
    logic [MW:0]             w_rem_sh;
    logic [MW:0]             w_diff;
    logic [MW-1:0]           w_rem_step;
    logic [HASH_W-1:0]       w_next_acc;
    logic                    w_last_probe;
    logic                    w_in_acc;

    // clamp register values to capacity
    assign w_bits_ext   = BCW'(r_bits_in_use);
    assign w_probes_ext = PCW'(r_probe_count);
    assign w_m_eff = (w_bits_ext > BCW'(MAX_BITS)) ? MW'(MAX_BITS) : MW'(w_bits_ext);
    assign w_k_eff = (w_probes_ext > PCW'(MAX_PROBES)) ? PW'(MAX_PROBES) : PW'(w_probes_ext);

    // shared restoring divider step, remainder only
    assign w_rem_sh   = {r_rem, r_dvd[HASH_W-1]};
    assign w_diff     = w_rem_sh - {1'b0, r_m};
    assign w_rem_step = w_diff[MW] ? w_rem_sh[MW-1:0] : w_diff[MW-1:0];

    // next probe base and end of probe sequence
    assign w_next_acc   = r_acc + r_stride;
    assign w_last_probe = (PW'(r_probe + 1'b1) == r_k);

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // sequencer: next state and datapath controls
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid;
        n_out_mp    = r_out_mp;
        n_cmd       = r_cmd;
        n_acc       = r_acc;
        n_dvd       = r_dvd;
        n_stride    = r_stride;
        n_m         = r_m;
        n_k         = r_k;
        n_probe     = r_probe;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_answer    = r_answer;
        w_mem_we    = 1'b0;
        w_mem_wd    = 1'b0;
        w_mem_addr  = r_rem[AW-1:0];

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                w_mem_we   = 1'b1;
                w_mem_wd   = 1'b0;
                w_mem_addr = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(MAX_BITS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_cmd    = i_cmd;
                    n_acc    = i_first_hash;
                    n_dvd    = i_first_hash;
                    n_stride = (i_second_hash == '0) ? HASH_W'(1) : i_second_hash;
                    n_m      = w_m_eff;
                    n_k      = w_k_eff;
                    n_probe  = '0;
                    n_cnt    = '0;
                    n_rem    = '0;
                    n_answer = (i_cmd == CMD_QUERY);
                    if (w_m_eff == '0) begin
                        n_answer = 1'b0;
                        n_state  = ST_DONE;
                    end else if (w_k_eff == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_rem = w_rem_step;
                n_dvd = {r_dvd[HASH_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(HASH_W - 1)) begin
                    n_state = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                if (r_cmd == CMD_ADD) begin
                    w_mem_we = 1'b1;
                    w_mem_wd = 1'b1;
                    if (w_last_probe) begin
                        n_state = ST_DONE;
                    end else begin
                        n_probe = PW'(r_probe + 1'b1);
                        n_acc   = w_next_acc;
                        n_dvd   = w_next_acc;
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_state = ST_DIV;
                    end
                end else begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (!r_rd_data) begin
                    n_answer = 1'b0;
                    n_state  = ST_DONE;
                end else if (w_last_probe) begin
                    n_state = ST_DONE;
                end else begin
                    n_probe = PW'(r_probe + 1'b1);
                    n_acc   = w_next_acc;
                    n_dvd   = w_next_acc;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_mp    = r_answer;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_in_use <= BITS_IN_USE_RST;
            r_probe_count <= PROBE_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_BITS_IN_USE: r_bits_in_use <= i_cfg_data[CFG_BITS_W-1:0];
                REG_PROBE_COUNT: r_probe_count <= i_cfg_data[CFG_PROBE_W-1:0];
                default: ;
            endcase
        end
    end

    // request payload and divider registers
    always_ff @(posedge i_clk) begin
        r_out_mp <= n_out_mp;
        r_cmd    <= n_cmd;
        r_acc    <= n_acc;
        r_dvd    <= n_dvd;
        r_stride <= n_stride;
        r_m      <= n_m;
        r_k      <= n_k;
        r_probe  <= n_probe;
        r_cnt    <= n_cnt;
        r_rem    <= n_rem;
        r_answer <= n_answer;
    end

    // bit store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wd;
        end
        r_rd_data <= r_mem[w_mem_addr];
    end

    assign o_out_valid     = r_out_valid;
    assign o_maybe_present = r_out_mp;

`ifndef SYNTH
    // probe index is fully reduced before the store is touched
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACCESS) |-> (r_rem < r_m))
        else $error("probe index not below bit count");

    // probe counter stays inside the probe count
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_probe < r_k))
        else $error("probe counter beyond probe count");

    // an accepted request starts work
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != ST_IDLE))
        else $error("accepted request did not start");

    // a result only appears from the completion state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside completion");
`endif

endmodule

### bench/tb_bloom_filter_double_hash_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bloom_filter_double_hash_unit
// Self-checking bench for the double-hashing bloom filter. A shadow copy of
// the bit store predicts each answer; requests are driven with random gaps,
// results are taken with random stalls, and the bit count and probe count
// are swept across their limits between phases while the unit is idle.
// ----------------------------------------------------------------------------

// shadow of the filter store and the two registers, with the answer queue
class bloom_tracker;
    localparam int STORE_BITS = 65536;
    localparam int PROBE_CAP  = 16;

    bit               filter_map [STORE_BITS];
    bit [16:0]        bits_in_use;
    bit [4:0]         probe_count;
    bit               pending_answers [$];
    int unsigned      adds;
    int unsigned      queries;
    int unsigned      hits;
    int unsigned      checked;
    int unsigned      failures;

    function new();
        foreach (filter_map[n]) filter_map[n] = 1'b0;
        bits_in_use = bfdh_pkg::BITS_IN_USE_RST;
        probe_count = bfdh_pkg::PROBE_COUNT_RST;
    endfunction

    function void write_register(logic [bfdh_pkg::CFG_IDX_W-1:0] idx,
                                 logic [bfdh_pkg::CFG_DATA_W-1:0] value);
        if (idx == bfdh_pkg::REG_BITS_IN_USE)
            bits_in_use = value[16:0];
        else if (idx == bfdh_pkg::REG_PROBE_COUNT)
            probe_count = value[4:0];
    endfunction

    // walk the probe sequence, setting bits for an add, testing them for a query
    function bit predict_answer(bit cmd, bit [63:0] h1, bit [63:0] h2);
        bit [63:0]   span;
        bit [63:0]   stride;
        bit [63:0]   slot;
        int unsigned probes;
        int unsigned p;
        bit          answer;
        span   = (bits_in_use > STORE_BITS) ? 64'(STORE_BITS) : 64'(bits_in_use);
        probes = (probe_count > PROBE_CAP) ? PROBE_CAP : probe_count;
        stride = (h2 == 64'd0) ? 64'd1 : h2;
        if (span == 64'd0)
            return 1'b0;
        answer = (cmd == bfdh_pkg::CMD_QUERY);
        for (p = 0; p < probes; p++) begin
            slot = (64'(p) * stride + h1) % span;
            if (cmd == bfdh_pkg::CMD_ADD) begin
                filter_map[slot[15:0]] = 1'b1;
            end else if (!filter_map[slot[15:0]]) begin
                answer = 1'b0;
                break;
            end
        end
        return answer;
    endfunction

    function void note_request(bit cmd, bit [63:0] h1, bit [63:0] h2);
        bit want;
        want = predict_answer(cmd, h1, h2);
        if (cmd == bfdh_pkg::CMD_ADD)
            adds++;
        else
            queries++;
        if (cmd == bfdh_pkg::CMD_QUERY && want)
            hits++;
        pending_answers.push_back(want);
    endfunction

    function void check_answer(logic got);
        bit want;
        checked++;
        if (pending_answers.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("result %0d arrived with none outstanding: got %b", checked, got);
            return;
        end
        want = pending_answers.pop_front();
        if (got !== want) begin
            failures++;
            if (failures <= 10)
                $display("result %0d maybe_present: expected %b, got %b", checked, want, got);
        end
    endfunction
endclass

module tb_bloom_filter_double_hash_unit;
    import bfdh_pkg::*;

    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES   = 1100;
    localparam int          HOLD_CYCLES   = 3000;
    localparam int unsigned CYCLE_LIMIT   = 4_000_000;
    localparam int          KEY_MEMORY    = 48;

    typedef struct packed {
        logic [HASH_W-1:0] h1;
        logic [HASH_W-1:0] h2;
    } t_key;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_cmd;
    logic [HASH_W-1:0]     i_first_hash;
    logic [HASH_W-1:0]     i_second_hash;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_maybe_present;

    bloom_tracker board;
    t_key         known_keys [$];
    int unsigned  sender_idle_pct;
    int unsigned  stall_pct;
    int unsigned  hold_request;
    int unsigned  hold_left;
    int unsigned  cycle_count;
    int unsigned  settings_used;

    bloom_filter_double_hash_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_first_hash   (i_first_hash),
        .i_second_hash  (i_second_hash),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_maybe_present(o_maybe_present)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run-length guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off when asked for
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_answer(o_maybe_present);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // offer one request after an optional gap and hold it until taken
    task automatic send_request(input logic cmd, input logic [63:0] h1,
                                input logic [63:0] h2);
        int unsigned gap;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct)
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 500) : $urandom_range(1, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_first_hash  <= h1;
        i_second_hash <= h2;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(cmd, h1, h2);
    endtask

    task automatic wait_drained();
        while (board.pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both registers on back-to-back cycles; upper data bits are noise
    // for the probe count
    task automatic set_filter(input logic [16:0] bit_count, input logic [4:0] probes);
        logic [CFG_DATA_W-1:0] probe_word;
        probe_word  = {12'($urandom), probes};
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_BITS_IN_USE;
        i_cfg_data  <= bit_count;
        @(posedge i_clk);
        board.write_register(REG_BITS_IN_USE, bit_count);
        i_cfg_index <= REG_PROBE_COUNT;
        i_cfg_data  <= probe_word;
        @(posedge i_clk);
        board.write_register(REG_PROBE_COUNT, probe_word);
        i_cfg_wr_en <= 1'b0;
        settings_used++;
        known_keys.delete();
    endtask

    // mostly adds and re-queries of added keys, some random misses and noise
    function automatic void pick_request(output logic cmd, output logic [63:0] h1,
                                         output logic [63:0] h2);
        int unsigned roll;
        t_key        key;
        roll = $urandom_range(99);
        if (roll < 40 || known_keys.size() == 0) begin
            cmd = CMD_ADD;
            h1  = rand64();
            h2  = ($urandom_range(15) == 0) ? 64'd0 : rand64();
            known_keys.push_back({h1, h2});
            if (known_keys.size() > KEY_MEMORY)
                void'(known_keys.pop_front());
        end else if (roll < 72) begin
            key = known_keys[$urandom_range(known_keys.size() - 1)];
            cmd = CMD_QUERY;
            h1  = key.h1;
            h2  = key.h2;
        end else if (roll < 90) begin
            cmd = CMD_QUERY;
            h1  = rand64();
            h2  = rand64();
        end else begin
            cmd = 1'($urandom_range(1));
            case ($urandom_range(2))
                0: h1 = 64'd0;
                1: h1 = '1;
                default: h1 = rand64();
            endcase
            case ($urandom_range(3))
                0: h2 = 64'd0;
                1: h2 = 64'd1;
                2: h2 = '1;
                default: h2 = 64'($urandom_range(65535));
            endcase
        end
    endfunction

    initial begin
        logic        cmd;
        logic [63:0] h1;
        logic [63:0] h2;
        logic [16:0] bit_count;
        logic [4:0]  probes;
        int unsigned count;
        bit          drain_each;
        int          ph;
        int          n;

        board           = new();
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_request    = 0;
        hold_left       = 0;
        cycle_count     = 0;
        settings_used   = 0;
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = REG_BITS_IN_USE;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_cmd           = CMD_ADD;
        i_first_hash    = '0;
        i_second_hash   = '0;
        i_out_stall     = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, zero stride, wrap-around of the probe sum
        send_request(CMD_QUERY, 64'd0, 64'd0);
        send_request(CMD_ADD,   64'd0, 64'd0);
        send_request(CMD_QUERY, 64'd0, 64'd0);
        send_request(CMD_QUERY, 64'd0, 64'd1);
        send_request(CMD_ADD,   '1, '1);
        send_request(CMD_QUERY, '1, '1);
        send_request(CMD_ADD,   64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(CMD_QUERY, 64'h0000_0000_0000_FFFF, 64'd0);
        i_in_valid <= 1'b0;
        wait_drained();

        // zero bit count: adds do nothing, queries miss
        set_filter(17'd0, 5'd7);
        h1 = rand64();
        h2 = rand64();
        send_request(CMD_ADD, h1, h2);
        send_request(CMD_QUERY, h1, h2);
        i_in_valid <= 1'b0;
        wait_drained();

        // both registers above capacity
        set_filter(17'h1FFFF, 5'd31);
        h1 = rand64();
        h2 = rand64();
        send_request(CMD_ADD, h1, h2);
        send_request(CMD_QUERY, h1, h2);
        send_request(CMD_QUERY, '1, 64'd0);
        i_in_valid <= 1'b0;
        wait_drained();

        // zero probe count: queries always hit
        set_filter(17'd65536, 5'd0);
        send_request(CMD_ADD, rand64(), rand64());
        send_request(CMD_QUERY, rand64(), rand64());
        i_in_valid <= 1'b0;
        wait_drained();

        // single-bit filter, single probe
        set_filter(17'd1, 5'd1);
        send_request(CMD_QUERY, rand64(), rand64());
        send_request(CMD_ADD, rand64(), rand64());
        send_request(CMD_QUERY, rand64(), rand64());
        i_in_valid <= 1'b0;
        wait_drained();

        // full size, full probe count, then a tiny filter with many probes
        set_filter(17'd65536, 5'd16);
        h1 = rand64();
        h2 = rand64();
        send_request(CMD_ADD, h1, h2);
        send_request(CMD_QUERY, h1, h2);
        send_request(CMD_QUERY, rand64(), rand64());
        i_in_valid <= 1'b0;
        wait_drained();
        set_filter(17'd8, 5'd16);
        send_request(CMD_QUERY, 64'd3, 64'd8);
        send_request(CMD_ADD, 64'd3, 64'd8);
        send_request(CMD_QUERY, 64'd11, 64'd0);
        i_in_valid <= 1'b0;
        wait_drained();

        // random phases, each with its own settings and idling pattern
        for (ph = 0; ph < 8; ph++) begin
            drain_each = 1'b0;
            case (ph)
                0: begin
                    bit_count = 17'd64;  probes = 5'd3;
                    sender_idle_pct = 0;  stall_pct = 0;  count = 70;
                end
                1: begin
                    bit_count = 17'd65536;  probes = 5'd16;
                    sender_idle_pct = 62; stall_pct = 0;  count = 25;
                end
                2: begin
                    bit_count = 17'($urandom_range(100, 5000));
                    probes    = 5'($urandom_range(1, 5));
                    sender_idle_pct = 0;  stall_pct = 62; count = 70;
                end
                3: begin
                    bit_count = 17'd1000;  probes = 5'd2;
                    sender_idle_pct = 6;  stall_pct = 6;  count = 70;
                end
                4: begin
                    bit_count = 17'($urandom_range(1, 300));
                    probes    = 5'($urandom_range(0, 6));
                    sender_idle_pct = 0;  stall_pct = 0;  count = 60;
                    drain_each = 1'b1;
                end
                5: begin
                    bit_count = 17'h1FFFF;  probes = 5'd1;
                    sender_idle_pct = 6;  stall_pct = 6;  count = 70;
                end
                6: begin
                    bit_count = 17'd17;  probes = 5'd20;
                    sender_idle_pct = 62; stall_pct = 0;  count = 60;
                end
                default: begin
                    bit_count = 17'($urandom_range(1, 65536));
                    probes    = 5'($urandom_range(0, 31));
                    sender_idle_pct = 0;  stall_pct = 62; count = 70;
                end
            endcase
            set_filter(bit_count, probes);
            // long output hold-off so the unit backs up and stalls its input
            if (ph == 3)
                hold_request = HOLD_CYCLES;
            for (n = 0; n < count; n++) begin
                pick_request(cmd, h1, h2);
                send_request(cmd, h1, h2);
                // sender waits for every outstanding result before going on
                if (drain_each) begin
                    i_in_valid <= 1'b0;
                    wait_drained();
                end
            end
            i_in_valid <= 1'b0;
            wait_drained();
        end

        sender_idle_pct = 0;
        stall_pct       = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d adds, %0d queries, %0d predicted hits)",
                 board.adds + board.queries, board.adds, board.queries, board.hits);
        $display("over %0d filter settings; %0d results checked, %0d failures",
                 settings_used, board.checked, board.failures);
        if (board.failures == 0 && board.pending_answers.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
